// ===== src/mbfs_pkg.sv =====
// ----------------------------------------------------------------------------
// mbfs_pkg
// Shared types, constants and the bit search for the mark bitmap free run sweep.
// ----------------------------------------------------------------------------
package mbfs_pkg;

  localparam int WORD_BITS  = 64;
  localparam int POS_W      = 6;
  localparam int LEN_W      = 7;
  localparam int INDEX_W    = 9;
  localparam int SLOT_W     = 15;
  localparam int TOTAL_W    = 19;

  typedef struct packed {
    logic [POS_W-1:0]     start;
    logic [LEN_W-1:0]     len;
    logic [WORD_BITS-1:0] rest;
    logic                 last;
  } run_info_t;

  // index of the lowest set bit, zero when none is set
  function automatic logic [LEN_W-1:0] lowest_one(input logic [WORD_BITS:0] v);
    logic [LEN_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS; i >= 0; i--) begin
      if (v[i]) begin
        idx = LEN_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== src/mbfs_run_unit.sv =====
// ----------------------------------------------------------------------------
// mbfs_run_unit
// Finds the lowest run of free slots in the remaining free bits of a word and
// returns its start, its length and the free bits left once it is removed.
// ----------------------------------------------------------------------------
module mbfs_run_unit (
  input  logic [63:0]           free_bits,
  output mbfs_pkg::run_info_t   info
);
  import mbfs_pkg::*;

  logic [WORD_BITS:0]   low_bit;
  logic [WORD_BITS:0]   carried;
  logic [LEN_W-1:0]     start_pos;
  logic [LEN_W-1:0]     end_pos;
  logic [WORD_BITS-1:0] rest;

  // adding the lowest set bit clears the lowest run and carries past its end
  assign low_bit   = {1'b0, free_bits & (~free_bits + WORD_BITS'(1))};
  assign carried   = {1'b0, free_bits} + low_bit;
  assign start_pos = lowest_one({1'b0, free_bits});
  assign end_pos   = lowest_one(carried);
  assign rest      = free_bits & carried[WORD_BITS-1:0];

  assign info.start = start_pos[POS_W-1:0];
  assign info.len   = end_pos - start_pos;
  assign info.rest  = rest;
  assign info.last  = (rest == '0);

endmodule

// ===== src/mark_bitmap_free_run_sweep.sv =====
// ----------------------------------------------------------------------------
// mark_bitmap_free_run_sweep
// Splits each 64-bit mark bitmap word into runs of free slots and reports each
// run with its start slot, length and the page's running reclaimed byte count.
//
//   channel   handshake             word
//   in        in_valid / in_ready   mark_word, page_end
//   out       out_valid / out_ready run_start_slot, run_length,
//                                   reclaimed_bytes, last_of_word
//
// a word is loaded first, then one free run (up to 32) is found per cycle while the
// output does not stall; the single run finder sets this rate
// a full word gives no result
// synchronous reset clears the slot base, the byte total and the output valid
// an output stall holds the run finder; in_ready is low while a word is swept
// ----------------------------------------------------------------------------
module mark_bitmap_free_run_sweep #(
  parameter int PAGE_WORDS = 512,
  parameter int SLOT_BYTES = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [63:0]                     mark_word,
  input  logic                            page_end,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mbfs_pkg::SLOT_W-1:0]     run_start_slot,
  output logic [mbfs_pkg::LEN_W-1:0]      run_length,
  output logic [mbfs_pkg::TOTAL_W-1:0]    reclaimed_bytes,
  output logic                            last_of_word
);
  import mbfs_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                 state;
  logic [WORD_BITS-1:0] free_bits;
  logic                 page_end_q;
  logic [INDEX_W-1:0]   word_index;
  logic [INDEX_W-1:0]   word_index_next;
  logic [TOTAL_W-1:0]   reclaimed_total;
  logic [TOTAL_W-1:0]   total_added;
  logic [TOTAL_W:0]     total_sum;
  logic [TOTAL_W:0]     run_byte_count;
  logic [INDEX_W:0]     index_inc;
  run_info_t            info;
  logic                 accept;
  logic                 emit;
  logic                 finish;

  mbfs_run_unit u_run (
    .free_bits (free_bits),
    .info      (info)
  );

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    emit      = (state == ST_RUN) && (free_bits != '0) && (!out_valid || out_ready);
    finish    = (state == ST_RUN) && ((free_bits == '0) || (emit && info.last));
    run_byte_count = (TOTAL_W+1)'(info.len) * (TOTAL_W+1)'(SLOT_BYTES);
    total_sum = {1'b0, reclaimed_total} + run_byte_count;
    total_added = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
    index_inc = {1'b0, word_index} + (INDEX_W+1)'(1);
    if (index_inc[INDEX_W] || (32'(index_inc) >= 32'(PAGE_WORDS))) begin
      word_index_next = '0;
    end else begin
      word_index_next = index_inc[INDEX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      out_valid       <= 1'b0;
      word_index      <= '0;
      reclaimed_total <= '0;
    end else begin
      if (accept) begin
        state <= ST_RUN;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (finish && page_end_q) begin
        reclaimed_total <= '0;
      end else if (emit) begin
        reclaimed_total <= total_added;
      end
      if (finish) begin
        state <= ST_IDLE;
        if (page_end_q) begin
          word_index <= '0;
        end else begin
          word_index <= word_index_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      free_bits  <= ~mark_word;
      page_end_q <= page_end;
    end else if (emit) begin
      free_bits <= info.rest;
    end
    if (emit) begin
      run_start_slot  <= {word_index, info.start};
      run_length      <= info.len;
      reclaimed_bytes <= total_added;
      last_of_word    <= info.last;
    end
  end

endmodule

// ===== src/mbfs_checker.sv =====
// ----------------------------------------------------------------------------
// mbfs_checker
// Port level checks for the mark bitmap free run sweep, bound to the top level.
// ----------------------------------------------------------------------------
module mbfs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] run_start_slot,
  input logic [6:0]  run_length,
  input logic [18:0] reclaimed_bytes,
  input logic        last_of_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(run_start_slot)
      && $stable(run_length) && $stable(reclaimed_bytes) && $stable(last_of_word))
    else $error("result word changed while stalled");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (run_length != 7'd0) && (run_length <= 7'd64))
    else $error("run length out of range");

  a_in_word: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({2'b00, run_start_slot[5:0]} + {1'b0, run_length}) <= 8'd64)
    else $error("run crosses a word boundary");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new word taken while sweeping");

endmodule

bind mark_bitmap_free_run_sweep mbfs_checker u_mbfs_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .run_start_slot  (run_start_slot),
  .run_length      (run_length),
  .reclaimed_bytes (reclaimed_bytes),
  .last_of_word    (last_of_word)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Checks the mark bitmap free run sweep against a behavioural predictor.
// Directed bitmap words cover empty, full, alternating and edge patterns;
// random pages follow with idle and stall gaps on both channels. A longer
// page of mostly empty words closes the run. Every run is compared field by
// field in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGE_WORDS = 512;
  localparam int SLOT_BYTES = 8;
  localparam int TOTAL_MAX  = (1 << mbfs_pkg::TOTAL_W) - 1;

  typedef struct {
    logic [63:0] bits;
    logic        last_word;
  } bitmap_word_t;

  typedef struct {
    logic [mbfs_pkg::SLOT_W-1:0]  slot;
    logic [mbfs_pkg::LEN_W-1:0]   len;
    logic [mbfs_pkg::TOTAL_W-1:0] bytes;
    logic                         last;
  } free_run_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [63:0]                  mark_word = 64'd0;
  logic                         page_end = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [mbfs_pkg::SLOT_W-1:0]  run_start_slot;
  logic [mbfs_pkg::LEN_W-1:0]   run_length;
  logic [mbfs_pkg::TOTAL_W-1:0] reclaimed_bytes;
  logic                         last_of_word;

  bitmap_word_t words_to_send[$];
  free_run_t    expected_runs[$];
  bitmap_word_t next_word;
  free_run_t    oldest_run;

  int  page_word_pos = 0;
  int  page_total = 0;
  int  words_swept = 0;
  int  runs_checked = 0;
  int  failures = 0;
  bit  no_idle = 1'b0;

  mark_bitmap_free_run_sweep #(
    .PAGE_WORDS(PAGE_WORDS),
    .SLOT_BYTES(SLOT_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mark_word(mark_word),
    .page_end(page_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .run_start_slot(run_start_slot),
    .run_length(run_length),
    .reclaimed_bytes(reclaimed_bytes),
    .last_of_word(last_of_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // free runs of one accepted word, then the page state moves on
  task automatic sweep_word(input logic [63:0] w, input logic last_in_page);
    int        b;
    int        s;
    free_run_t run;
    b = 0;
    while (b < 64) begin
      if (w[b]) begin
        b++;
      end else begin
        s = b;
        while (b < 64 && !w[b]) b++;
        page_total = page_total + (b - s) * SLOT_BYTES;
        if (page_total > TOTAL_MAX) page_total = TOTAL_MAX;
        run.slot  = mbfs_pkg::SLOT_W'(page_word_pos * 64 + s);
        run.len   = mbfs_pkg::LEN_W'(b - s);
        run.bytes = mbfs_pkg::TOTAL_W'(page_total);
        run.last  = (((~w) >> b) == 64'd0);
        expected_runs = {expected_runs, run};
      end
    end
    if (last_in_page) begin
      page_word_pos = 0;
      page_total = 0;
    end else if (page_word_pos + 1 >= PAGE_WORDS || page_word_pos + 1 > 511) begin
      page_word_pos = 0;
    end else begin
      page_word_pos++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        sweep_word(mark_word, page_end);
        words_swept++;
      end
      if (!in_valid || in_ready) begin
        if (words_to_send.size() != 0 && (no_idle || $urandom_range(0, 99) >= 25)) begin
          next_word = words_to_send.pop_front();
          in_valid  <= 1'b1;
          mark_word <= next_word.bits;
          page_end  <= next_word.last_word;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_runs.size() == 0) begin
          $error("unexpected run: start %0d length %0d", run_start_slot, run_length);
          failures++;
        end else begin
          oldest_run = expected_runs.pop_front();
          if (run_start_slot !== oldest_run.slot) begin
            $error("run_start_slot: expected %0d, got %0d", oldest_run.slot, run_start_slot);
            failures++;
          end
          if (run_length !== oldest_run.len) begin
            $error("run_length: expected %0d, got %0d", oldest_run.len, run_length);
            failures++;
          end
          if (reclaimed_bytes !== oldest_run.bytes) begin
            $error("reclaimed_bytes: expected %0d, got %0d", oldest_run.bytes,
                   reclaimed_bytes);
            failures++;
          end
          if (last_of_word !== oldest_run.last) begin
            $error("last_of_word: expected %0d, got %0d", oldest_run.last, last_of_word);
            failures++;
          end
        end
        runs_checked++;
      end
      out_ready <= no_idle || ($urandom_range(0, 99) >= 25);
    end
  end

  task automatic queue_word(input logic [63:0] bits, input logic last_word);
    bitmap_word_t item;
    item.bits = bits;
    item.last_word = last_word;
    words_to_send = {words_to_send, item};
  endtask

  // wait until every word is taken and every run has come out
  task automatic settle(input int limit_cycles);
    int n;
    n = 0;
    while ((words_to_send.size() != 0 || in_valid || expected_runs.size() != 0)
           && n < limit_cycles) begin
      @(negedge clk);
      n++;
    end
    @(negedge clk);
  endtask

  function automatic logic [63:0] random_mark_word();
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] m;
    int          lo;
    int          hi;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2: return a;
      3:       return a & b & c;
      4:       return a | b | c;
      5:       return ~64'd0;
      6:       return 64'd0;
      7:       return 64'h5555_5555_5555_5555 << $urandom_range(0, 1);
      8: begin
        lo = $urandom_range(0, 63);
        hi = $urandom_range(lo, 63);
        m = ~64'd0;
        for (int i = lo; i <= hi; i++) m[i] = 1'b0;
        return m;
      end
      default: return a & b;
    endcase
  endfunction

  task automatic queue_random_pages(input int count);
    int queued;
    int page_len;
    bit closed;
    queued = 0;
    while (queued < count) begin
      page_len = $urandom_range(1, 16);
      closed = ($urandom_range(0, 5) != 0);
      for (int i = 0; i < page_len; i++) begin
        queue_word(random_mark_word(), closed && i == page_len - 1);
      end
      queued += page_len;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    queue_word(64'd0, 1'b0);
    queue_word(~64'd0, 1'b0);
    queue_word(64'h5555_5555_5555_5555, 1'b0);
    queue_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    queue_word(64'h0000_0000_0000_0001, 1'b0);
    queue_word(64'h8000_0000_0000_0000, 1'b0);
    queue_word(~64'h0000_0000_0000_0001, 1'b0);
    queue_word(~64'h8000_0000_0000_0000, 1'b0);
    queue_word(64'h8000_0000_0000_0001, 1'b0);
    queue_word(64'h0000_0000_FFFF_FFFF, 1'b1);
    queue_word(~64'd0, 1'b1);
    queue_word(64'd0, 1'b1);
    queue_word(64'hFFFF_FFFF_0000_0000, 1'b0);
    queue_word(64'h0F0F_0F0F_0F0F_0F0F, 1'b0);
    queue_word(64'd0, 1'b1);
    settle(20000);

    queue_random_pages(130);
    settle(40000);

    no_idle = 1'b1;
    queue_random_pages(110);
    settle(40000);
    no_idle = 1'b0;

    queue_random_pages(120);
    settle(40000);

    // one longer page of mostly empty words
    for (int i = 0; i < 30; i++) begin
      queue_word(($urandom_range(0, 19) == 0) ? random_mark_word() : 64'd0, 1'b0);
    end
    queue_word(random_mark_word(), 1'b1);
    settle(60000);

    repeat (40) @(negedge clk);
    if (expected_runs.size() != 0) begin
      $error("%0d expected runs never came out", expected_runs.size());
      failures++;
    end

    $display("swept %0d bitmap words over directed, random and longer pages",
             words_swept);
    $display("compared %0d free runs with %0d field mismatches", runs_checked, failures);
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
